[rtl/sfsp_pkg.sv]
package sfsp_pkg;

	// item kinds after classification
	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_PREFIX = 3'd1;
	localparam logic [2:0] KIND_SPACE  = 3'd2;
	localparam logic [2:0] KIND_DIGIT  = 3'd3;
	localparam logic [2:0] KIND_DOUBLE = 3'd4;
	localparam logic [2:0] KIND_OTHER  = 3'd5;

	// byte order codes
	localparam logic [1:0] ORD_NATIVE = 2'd0;
	localparam logic [1:0] ORD_LITTLE = 2'd1;
	localparam logic [1:0] ORD_BIG    = 2'd2;

	// status codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_SPACE = 2'd1;
	localparam logic [1:0] ERR_LONG  = 2'd2;
	localparam logic [1:0] ERR_CHAR  = 2'd3;

	// characters of interest
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// result field widths
	localparam int STATUS_W = 2;
	localparam int ORDER_W  = 2;
	localparam int COUNT_W  = 63;
	localparam int OUT_W    = 136;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// classified item handed from front to back
	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] ord;
		logic [3:0] digit;
		logic       last;
	} item_t;

endpackage

[rtl/sfsp_front.sv]
module sfsp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_char,
	input  logic                in_has,
	input  logic                in_last,
	input  logic                push_ready,
	output logic                push_valid,
	output sfsp_pkg::item_t     push_item
);

	logic first_q;
	logic accept;

	assign accept     = in_valid && push_ready;
	assign push_valid = in_valid;

	// track whether the next character opens the string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (accept) begin
			if (in_last) begin
				first_q <= 1'b1;
			end else if (in_has) begin
				first_q <= 1'b0;
			end
		end
	end

	// classify the character
	always_comb begin
		push_item.kind  = sfsp_pkg::KIND_OTHER;
		push_item.ord   = sfsp_pkg::ORD_NATIVE;
		push_item.digit = 4'(in_char - sfsp_pkg::CH_ZERO);
		push_item.last  = in_last;
		if (!in_has) begin
			push_item.kind = sfsp_pkg::KIND_NONE;
		end else if (first_q && (in_char == sfsp_pkg::CH_LT)) begin
			push_item.kind = sfsp_pkg::KIND_PREFIX;
			push_item.ord  = sfsp_pkg::ORD_LITTLE;
		end else if (first_q && ((in_char == sfsp_pkg::CH_GT) ||
				(in_char == sfsp_pkg::CH_BANG))) begin
			push_item.kind = sfsp_pkg::KIND_PREFIX;
			push_item.ord  = sfsp_pkg::ORD_BIG;
		end else if (first_q && ((in_char == sfsp_pkg::CH_EQ) ||
				(in_char == sfsp_pkg::CH_AT))) begin
			push_item.kind = sfsp_pkg::KIND_PREFIX;
			push_item.ord  = sfsp_pkg::ORD_NATIVE;
		end else if (in_char inside {[sfsp_pkg::CH_TAB:sfsp_pkg::CH_CR],
				sfsp_pkg::CH_SPACE}) begin
			push_item.kind = sfsp_pkg::KIND_SPACE;
		end else if (in_char inside {[sfsp_pkg::CH_ZERO:sfsp_pkg::CH_NINE]}) begin
			push_item.kind = sfsp_pkg::KIND_DIGIT;
		end else if (in_char == sfsp_pkg::CH_D) begin
			push_item.kind = sfsp_pkg::KIND_DOUBLE;
		end
	end

endmodule

[rtl/sfsp_queue.sv]
module sfsp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  sfsp_pkg::item_t push_item,
	output logic            push_ready,
	output logic            pop_valid,
	output sfsp_pkg::item_t pop_item,
	input  logic            pop_ready
);

	localparam int PTR_W = (sfsp_pkg::QUEUE_DEPTH > 1) ? $clog2(sfsp_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(sfsp_pkg::QUEUE_DEPTH + 1);

	sfsp_pkg::item_t  entry_q [sfsp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(sfsp_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(sfsp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(sfsp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/sfsp_back.sv]
module sfsp_back #(
	parameter int LIMIT_BITS = 63
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pop_valid,
	input  sfsp_pkg::item_t            pop_item,
	output logic                       pop_ready,
	output logic                       out_valid,
	output logic [sfsp_pkg::OUT_W-1:0] out_data,
	input  logic                       out_ready
);

	localparam int LB = LIMIT_BITS;

	logic [1:0]    order_q;
	logic [LB-1:0] pend_q;
	logic          given_q;
	logic [LB-1:0] items_q;
	logic [LB-1:0] bytes_q;
	logic [1:0]    err_q;

	logic [1:0]    order_nx;
	logic [LB-1:0] pend_nx;
	logic          given_nx;
	logic [LB-1:0] items_nx;
	logic [LB-1:0] bytes_nx;
	logic [1:0]    err_nx;

	logic                       valid_q;
	logic [sfsp_pkg::OUT_W-1:0] data_q;
	logic [sfsp_pkg::OUT_W-1:0] result;

	logic          take;
	logic [LB+3:0] pend_wide;
	logic [LB+3:0] dig_sum;
	logic [LB-1:0] n;
	logic [LB-1:0] n8;
	logic [LB:0]   bsum;
	logic [LB:0]   isum;
	logic          d_ovf;

	assign take      = pop_valid && (!pop_item.last || !valid_q || out_ready);
	assign pop_ready = take;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// repeat count times ten plus digit, checked against the limit
	assign pend_wide = {4'b0, pend_q};
	assign dig_sum   = (pend_wide << 3) + (pend_wide << 1) + (LB+4)'(pop_item.digit);

	// totals after one more double group
	assign n     = given_q ? pend_q : LB'(1);
	assign n8    = {n[LB-4:0], 3'b0};
	assign bsum  = {1'b0, bytes_q} + {1'b0, n8};
	assign isum  = {1'b0, items_q} + {1'b0, n};
	assign d_ovf = (n[LB-1:LB-3] != 3'b0) || bsum[LB] || isum[LB];

	// next parse state
	always_comb begin
		order_nx = order_q;
		pend_nx  = pend_q;
		given_nx = given_q;
		items_nx = items_q;
		bytes_nx = bytes_q;
		err_nx   = err_q;
		if (err_q == sfsp_pkg::ERR_NONE) begin
			case (pop_item.kind)
				sfsp_pkg::KIND_NONE: begin
				end
				sfsp_pkg::KIND_PREFIX: begin
					order_nx = pop_item.ord;
				end
				sfsp_pkg::KIND_SPACE: begin
					if (given_q) begin
						err_nx = sfsp_pkg::ERR_SPACE;
					end
				end
				sfsp_pkg::KIND_DIGIT: begin
					if (dig_sum[LB+3:LB] != 4'b0) begin
						err_nx = sfsp_pkg::ERR_LONG;
					end else begin
						pend_nx  = dig_sum[LB-1:0];
						given_nx = 1'b1;
					end
				end
				sfsp_pkg::KIND_DOUBLE: begin
					if (d_ovf) begin
						err_nx = sfsp_pkg::ERR_LONG;
					end else begin
						bytes_nx = bsum[LB-1:0];
						items_nx = isum[LB-1:0];
						pend_nx  = '0;
						given_nx = 1'b0;
					end
				end
				default: begin
					err_nx = sfsp_pkg::ERR_CHAR;
				end
			endcase
		end
	end

	// result item from the state after this character
	always_comb begin
		result = '0;
		result[1:0] = err_nx;
		if (err_nx == sfsp_pkg::ERR_NONE) begin
			result[3:2]   = order_nx;
			result[66:4]  = sfsp_pkg::COUNT_W'(items_nx);
			result[129:67] = sfsp_pkg::COUNT_W'(bytes_nx);
		end
	end

	// parse state, back to initial after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= sfsp_pkg::ORD_NATIVE;
			pend_q  <= '0;
			given_q <= 1'b0;
			items_q <= '0;
			bytes_q <= '0;
			err_q   <= sfsp_pkg::ERR_NONE;
		end else if (take) begin
			if (pop_item.last) begin
				order_q <= sfsp_pkg::ORD_NATIVE;
				pend_q  <= '0;
				given_q <= 1'b0;
				items_q <= '0;
				bytes_q <= '0;
				err_q   <= sfsp_pkg::ERR_NONE;
			end else begin
				order_q <= order_nx;
				pend_q  <= pend_nx;
				given_q <= given_nx;
				items_q <= items_nx;
				bytes_q <= bytes_nx;
				err_q   <= err_nx;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take && pop_item.last) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pop_item.last) begin
			data_q <= result;
		end
	end

endmodule

[rtl/struct_format_string_parser_unit.sv]
// a last item passes the queue entry register and then the output register before its result item shows on m_tvalid
// throughput: one format character per cycle; the back end updates its parse state as each item is taken
// a result waiting in the output register holds back only a following last item
// reset: arst_n low clears the queue, the parse state and the output register at once
module struct_format_string_parser_unit #(
	parameter int LIMIT_BITS = 63
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // character
	input  logic [0:0]                 s_tuser,  // has_char
	input  logic                       s_tlast,  // last_char
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// status, order of bytes, number of doubles, packed size, zero fill
	output logic [sfsp_pkg::OUT_W-1:0] m_tdata
);

	logic            push_valid;
	logic            push_ready;
	sfsp_pkg::item_t push_item;
	logic            pop_valid;
	logic            pop_ready;
	sfsp_pkg::item_t pop_item;

	assign s_tready = push_ready;

	// character classification
	sfsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_char    (s_tdata),
		.in_has     (s_tuser[0]),
		.in_last    (s_tlast),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_item  (push_item)
	);

	// decoupling queue
	sfsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	// count and size accumulation
	sfsp_back #(
		.LIMIT_BITS (LIMIT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop_ready (pop_ready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_ready (m_tready)
	);

endmodule

[sim/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_BITS = 63;
	localparam longint unsigned MAX_TOTAL = (64'd1 << LIMIT_BITS) - 64'd1;
	localparam int RANDOM_ITEMS = 750;
	localparam int CYCLE_LIMIT = 500000;

	// blanks not named in the package
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_VT = 8'h0b;
	localparam logic [7:0] CH_FF = 8'h0c;

	localparam logic [7:0] PREFIX_CHARS [5] = '{sfsp_pkg::CH_LT, sfsp_pkg::CH_GT,
		sfsp_pkg::CH_BANG, sfsp_pkg::CH_EQ, sfsp_pkg::CH_AT};
	localparam logic [7:0] BLANK_CHARS [6] = '{sfsp_pkg::CH_SPACE, sfsp_pkg::CH_TAB,
		sfsp_pkg::CH_CR, CH_LF, CH_VT, CH_FF};

	typedef struct packed {
		logic [7:0] ch;
		logic       has;
		logic       last;
	} fmt_item_t;

	typedef struct packed {
		logic [sfsp_pkg::STATUS_W-1:0] status;
		logic [sfsp_pkg::ORDER_W-1:0]  order;
		logic [sfsp_pkg::COUNT_W-1:0]  doubles;
		logic [sfsp_pkg::COUNT_W-1:0]  bytes;
	} summary_t;

	typedef struct {
		string    text;
		bit       empty_end;
		bit       spaced;
		bit       typed;
		summary_t want;
	} format_case_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [7:0]                 s_tdata = '0;
	logic [0:0]                 s_tuser = '0;
	logic                       s_tlast = 1'b0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [sfsp_pkg::OUT_W-1:0] m_tdata;

	// parser state mirrored by the testbench
	bit                  fresh_string;
	logic [1:0]          order_now;
	longint unsigned     count_acc;
	bit                  count_seen;
	longint unsigned     doubles_sum;
	longint unsigned     bytes_sum;
	logic [1:0]          err_now;

	summary_t            expected_summaries[$];
	fmt_item_t           pending_chars[$];
	format_case_t        directed_cases[$];

	int                  mismatches = 0;
	int                  cycle_count = 0;
	int                  formats_sent = 0;
	int                  chars_sent = 0;
	int                  results_checked = 0;
	bit                  quiet_in = 1'b0;
	bit                  quiet_out = 1'b0;

	struct_format_string_parser_unit #(
		.LIMIT_BITS(LIMIT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				expected_summaries.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic bit is_blank(input logic [7:0] c);
		return c == sfsp_pkg::CH_SPACE || c == sfsp_pkg::CH_TAB || c == sfsp_pkg::CH_CR ||
			c == CH_LF || c == CH_VT || c == CH_FF;
	endfunction

	task automatic clear_parser();
		fresh_string = 1'b1;
		order_now = sfsp_pkg::ORD_NATIVE;
		count_acc = 0;
		count_seen = 1'b0;
		doubles_sum = 0;
		bytes_sum = 0;
		err_now = sfsp_pkg::ERR_NONE;
	endtask

	// advance the mirrored parser by one item, give the summary on a last item
	task automatic parse_step(input fmt_item_t it, output bit emits, output summary_t res);
		longint unsigned dig;
		longint unsigned n;
		bit first;
		emits = 1'b0;
		res = '0;
		if (it.has) begin
			first = fresh_string;
			fresh_string = 1'b0;
			if (err_now == sfsp_pkg::ERR_NONE) begin
				if (first && (it.ch == sfsp_pkg::CH_LT || it.ch == sfsp_pkg::CH_GT ||
						it.ch == sfsp_pkg::CH_BANG || it.ch == sfsp_pkg::CH_EQ ||
						it.ch == sfsp_pkg::CH_AT)) begin
					case (it.ch)
						sfsp_pkg::CH_LT: order_now = sfsp_pkg::ORD_LITTLE;
						sfsp_pkg::CH_EQ, sfsp_pkg::CH_AT: order_now = sfsp_pkg::ORD_NATIVE;
						default: order_now = sfsp_pkg::ORD_BIG;
					endcase
				end else if (is_blank(it.ch)) begin
					if (count_seen)
						err_now = sfsp_pkg::ERR_SPACE;
				end else if (it.ch >= sfsp_pkg::CH_ZERO && it.ch <= sfsp_pkg::CH_NINE) begin
					dig = it.ch - sfsp_pkg::CH_ZERO;
					if (count_acc > (MAX_TOTAL - dig) / 10) begin
						err_now = sfsp_pkg::ERR_LONG;
					end else begin
						count_acc = count_acc * 10 + dig;
						count_seen = 1'b1;
					end
				end else if (it.ch != sfsp_pkg::CH_D) begin
					err_now = sfsp_pkg::ERR_CHAR;
				end else begin
					n = count_seen ? count_acc : 64'd1;
					if (n > MAX_TOTAL / 8 || bytes_sum > MAX_TOTAL - n * 8 ||
							doubles_sum > MAX_TOTAL - n) begin
						err_now = sfsp_pkg::ERR_LONG;
					end else begin
						bytes_sum += n * 8;
						doubles_sum += n;
						count_acc = 0;
						count_seen = 1'b0;
					end
				end
			end
		end
		if (it.last) begin
			emits = 1'b1;
			res.status = err_now;
			if (err_now == sfsp_pkg::ERR_NONE) begin
				res.order = order_now;
				res.doubles = doubles_sum[sfsp_pkg::COUNT_W-1:0];
				res.bytes = bytes_sum[sfsp_pkg::COUNT_W-1:0];
			end
			clear_parser();
		end
	endtask

	// drive one item after a random gap, then predict once it is taken
	task automatic send_item(input fmt_item_t it, input bit typed, input summary_t typed_val);
		int gap;
		bit emits;
		summary_t want;
		gap = quiet_in ? 0 : $urandom_range(0, 18);
		if ($urandom_range(0, 49) == 0)
			quiet_in = !quiet_in;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it.ch;
		s_tuser <= it.has;
		s_tlast <= it.last;
		do @(posedge clk); while (!s_tready);
		parse_step(it, emits, want);
		if (emits)
			expected_summaries.push_back(typed ? typed_val : want);
		if (it.has || it.last)
			chars_sent++;
	endtask

	task automatic append_char(input logic [7:0] c);
		pending_chars.push_back('{c, 1'b1, 1'b0});
	endtask

	task automatic append_text(input string s);
		for (int i = 0; i < s.len(); i++)
			append_char(s[i]);
	endtask

	// mark the end: on the final character or by an empty closing item
	task automatic finish_format(input bit empty_end);
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		if (empty_end || pending_chars.size() == 0)
			pending_chars.push_back('{junk, 1'b0, 1'b1});
		else
			pending_chars[pending_chars.size()-1].last = 1'b1;
	endtask

	task automatic send_format(input bit spaced, input bit typed, input summary_t want);
		fmt_item_t idle_item;
		for (int i = 0; i < pending_chars.size(); i++) begin
			if (spaced || $urandom_range(0, 19) == 0) begin
				idle_item = '{8'($urandom_range(0, 255)), 1'b0, 1'b0};
				send_item(idle_item, 1'b0, want);
			end
			send_item(pending_chars[i], typed, want);
		end
		formats_sent++;
	endtask

	task automatic add_case(input string text, input bit empty_end, input bit spaced,
			input bit typed, input logic [1:0] st, input logic [1:0] ord,
			input longint unsigned n, input longint unsigned b);
		format_case_t fc;
		fc.text = text;
		fc.empty_end = empty_end;
		fc.spaced = spaced;
		fc.typed = typed;
		fc.want = '{st, ord, n[sfsp_pkg::COUNT_W-1:0], b[sfsp_pkg::COUNT_W-1:0]};
		directed_cases.push_back(fc);
	endtask

	// random format: mostly well formed, some corrupted, some pure noise
	task automatic build_random_format();
		int style;
		int pos;
		int digit_pos[$];
		longint unsigned wide;
		pending_chars.delete();
		style = $urandom_range(0, 99);
		if (style >= 85) begin
			repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 1))
				append_char(PREFIX_CHARS[$urandom_range(0, 4)]);
			repeat ($urandom_range(0, 5)) begin
				if ($urandom_range(0, 3) == 0)
					append_char(BLANK_CHARS[$urandom_range(0, 5)]);
				case ($urandom_range(0, 9))
					0, 1, 2, 3: ;
					4, 5, 6: append_text($sformatf("%0d", $urandom_range(0, 99)));
					7: append_text($sformatf("%0d", $urandom_range(0, 9999)));
					8: begin
						wide = {$urandom, $urandom};
						wide = wide >> $urandom_range(0, 63);
						append_text($sformatf("%0d", wide));
					end
					default: append_text($sformatf("%0d", MAX_TOTAL / 8 - $urandom_range(0, 3)));
				endcase
				append_char(sfsp_pkg::CH_D);
			end
			// dangling count
			if ($urandom_range(0, 9) == 0)
				append_text($sformatf("%0d", $urandom_range(0, 999)));
			if (style >= 65) begin
				pos = $urandom_range(0, pending_chars.size());
				case ($urandom_range(0, 2))
					0: pending_chars.insert(pos, '{8'($urandom_range(0, 255)), 1'b1, 1'b0});
					1: pending_chars.insert(pos,
						'{PREFIX_CHARS[$urandom_range(0, 4)], 1'b1, 1'b0});
					default: begin
						foreach (pending_chars[i])
							if (pending_chars[i].ch >= sfsp_pkg::CH_ZERO &&
									pending_chars[i].ch <= sfsp_pkg::CH_NINE)
								digit_pos.push_back(i);
						if (digit_pos.size() > 0)
							pos = digit_pos[$urandom_range(0, digit_pos.size() - 1)] + 1;
						pending_chars.insert(pos,
							'{BLANK_CHARS[$urandom_range(0, 5)], 1'b1, 1'b0});
					end
				endcase
			end
		end
		finish_format($urandom_range(0, 6) == 0);
	endtask

	// result side: random stalls, compare each result with the oldest summary due
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = quiet_out ? 0 : $urandom_range(0, 18);
			if ($urandom_range(0, 19) == 0)
				quiet_out = !quiet_out;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		summary_t want;
		summary_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tdata[sfsp_pkg::STATUS_W-1:0];
			got.order = m_tdata[sfsp_pkg::STATUS_W +: sfsp_pkg::ORDER_W];
			got.doubles = m_tdata[sfsp_pkg::STATUS_W+sfsp_pkg::ORDER_W +: sfsp_pkg::COUNT_W];
			got.bytes = m_tdata[sfsp_pkg::STATUS_W+sfsp_pkg::ORDER_W+sfsp_pkg::COUNT_W +:
				sfsp_pkg::COUNT_W];
			if (expected_summaries.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = expected_summaries.pop_front();
				results_checked++;
				if (got.status != want.status)
					report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.order != want.order)
					report_mismatch($sformatf("order %0d, want %0d", got.order, want.order));
				if (got.doubles != want.doubles)
					report_mismatch($sformatf("doubles %0d, want %0d", got.doubles,
						want.doubles));
				if (got.bytes != want.bytes)
					report_mismatch($sformatf("packed size %0d, want %0d", got.bytes,
						want.bytes));
			end
		end
	end

	// stimulus
	initial begin
		int random_start;
		clear_parser();
		add_case("", 1'b1, 1'b0, 1'b1, sfsp_pkg::ERR_NONE, sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("<", 1'b0, 1'b0, 1'b1, sfsp_pkg::ERR_NONE, sfsp_pkg::ORD_LITTLE, 0, 0);
		add_case(">d", 1'b0, 1'b0, 1'b1, sfsp_pkg::ERR_NONE, sfsp_pkg::ORD_BIG, 1, 8);
		add_case("!2d", 1'b0, 1'b0, 1'b0, sfsp_pkg::ERR_NONE, sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("=d 3d", 1'b0, 1'b1, 1'b0, sfsp_pkg::ERR_NONE, sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("@\011\015\012\013\014d", 1'b0, 1'b0, 1'b0, sfsp_pkg::ERR_NONE,
			sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("d<", 1'b0, 1'b0, 1'b1, sfsp_pkg::ERR_CHAR, sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("3 d", 1'b0, 1'b0, 1'b1, sfsp_pkg::ERR_SPACE, sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("\377", 1'b0, 1'b0, 1'b1, sfsp_pkg::ERR_CHAR, sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("x<d", 1'b0, 1'b0, 1'b1, sfsp_pkg::ERR_CHAR, sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("7", 1'b0, 1'b0, 1'b1, sfsp_pkg::ERR_NONE, sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("99999999999999999999d", 1'b0, 1'b0, 1'b1, sfsp_pkg::ERR_LONG,
			sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("9999999999999999999d", 1'b0, 1'b0, 1'b1, sfsp_pkg::ERR_LONG,
			sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("1152921504606846975dd", 1'b0, 1'b0, 1'b1, sfsp_pkg::ERR_LONG,
			sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("<1152921504606846975d", 1'b0, 1'b0, 1'b0, sfsp_pkg::ERR_NONE,
			sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("<5d", 1'b0, 1'b1, 1'b0, sfsp_pkg::ERR_NONE, sfsp_pkg::ORD_NATIVE, 0, 0);
		add_case("10d9", 1'b1, 1'b0, 1'b0, sfsp_pkg::ERR_NONE, sfsp_pkg::ORD_NATIVE, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_cases[i]) begin
			pending_chars.delete();
			append_text(directed_cases[i].text);
			finish_format(directed_cases[i].empty_end);
			send_format(directed_cases[i].spaced, directed_cases[i].typed,
				directed_cases[i].want);
		end

		// random formats
		random_start = chars_sent;
		while (chars_sent - random_start < RANDOM_ITEMS) begin
			build_random_format();
			send_format(1'b0, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// drain, then watch for anything stray
		while (expected_summaries.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("sent %0d format strings in %0d items, %0d summaries checked",
			formats_sent, chars_sent, results_checked);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/sfsp_pkg.sv
rtl/sfsp_front.sv
rtl/sfsp_queue.sv
rtl/sfsp_back.sv
rtl/struct_format_string_parser_unit.sv
sim/testbench.sv
